@@ rtl/dwm_pkg.sv @@
package dwm_pkg;

  // default widths of the shared timer and the retry limit compare
  localparam int unsigned TimerWidthDef = 16;
  localparam int unsigned RetryWidthDef = 8;

  // fixed register field widths
  localparam int unsigned PeriodW  = 16;
  localparam int unsigned LimitW   = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [1:0] {
    PhPowerOn  = 2'd0,
    PhInitWait = 2'd1,
    PhRun      = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ActTick  = 2'd0,
    ActAck   = 2'd1,
    ActKick  = 2'd2,
    ActReset = 2'd3
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgInitPeriod  = 3'd0,
    CfgWdPeriod    = 3'd1,
    CfgInitWaitEn  = 3'd2,
    CfgInitRetryEn = 3'd3,
    CfgWdEn        = 3'd4,
    CfgRetryLimit  = 3'd5
  } cfg_idx_e;

  // configuration seen by the step logic
  typedef struct packed {
    logic [PeriodW-1:0] init_period;
    logic [PeriodW-1:0] wd_period;
    logic               init_wait_en;
    logic               init_retry_en;
    logic               wd_en;
    logic [LimitW-1:0]  retry_limit;
  } cfg_t;

  // single-bit supervisor state
  typedef struct packed {
    logic start;
    logic active;
    logic expired;
    logic expiry_evt;
    logic ack_cleared;
    logic ack_success;
  } flags_t;

  typedef struct packed {
    phase_e phase;
    logic   done_evt;
    logic   limit_evt;
    logic   wd_evt;
    logic   done_pending;
    logic   limit_reached;
    logic   wd_expired;
  } result_t;

endpackage

@@ rtl/device_init_watchdog_monitor_core.sv @@
// result: each accepted input's result is written straight into the output register
// throughput: one item per cycle while the consumer takes results, the whole step is
//   one combinational pass between the input handshake and the result register
// reset: asynchronous, active low; phase power-on, timer and flags cleared,
//   registers back to their reset values, output register empty
module device_init_watchdog_monitor_core #(
  parameter int unsigned TIMER_WIDTH = dwm_pkg::TimerWidthDef,
  parameter int unsigned RETRY_WIDTH = dwm_pkg::RetryWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [dwm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dwm_pkg::CfgDataW-1:0]  cfg_data_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    action_i,
  input  logic                          init_success_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    phase_o,
  output logic                          init_timer_done_event_o,
  output logic                          retry_limit_event_o,
  output logic                          watchdog_timeout_event_o,
  output logic                          init_done_pending_o,
  output logic                          retry_limit_reached_o,
  output logic                          watchdog_expired_o
);
  import dwm_pkg::*;

  // configuration registers
  cfg_t                   cfg_q;

  // supervisor state
  phase_e                 phase_q, phase_d;
  logic [TIMER_WIDTH-1:0] count_q, count_d;
  logic [TIMER_WIDTH-1:0] period_q, period_d;
  logic [RETRY_WIDTH:0]   retry_q, retry_d;
  flags_t                 flags_q, flags_d;

  // result register
  logic                   out_valid_q;
  result_t                res_q, res_d;

  logic                   in_xfer;

  // take a new item whenever the result register is empty or drains now
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  // register writes land at once; write them only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.init_period   <= {{(PeriodW-1){1'b0}}, 1'b1};
      cfg_q.wd_period     <= {{(PeriodW-1){1'b0}}, 1'b1};
      cfg_q.init_wait_en  <= 1'b0;
      cfg_q.init_retry_en <= 1'b0;
      cfg_q.wd_en         <= 1'b0;
      cfg_q.retry_limit   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgInitPeriod:  cfg_q.init_period   <= cfg_data_i[PeriodW-1:0];
        CfgWdPeriod:    cfg_q.wd_period     <= cfg_data_i[PeriodW-1:0];
        CfgInitWaitEn:  cfg_q.init_wait_en  <= cfg_data_i[0];
        CfgInitRetryEn: cfg_q.init_retry_en <= cfg_data_i[0];
        CfgWdEn:        cfg_q.wd_en         <= cfg_data_i[0];
        CfgRetryLimit:  cfg_q.retry_limit   <= cfg_data_i[LimitW-1:0];
        default: begin
        end
      endcase
    end
  end

  // phase logic and shared timer for one item
  dwm_step #(
    .TIMER_WIDTH (TIMER_WIDTH),
    .RETRY_WIDTH (RETRY_WIDTH)
  ) u_step (
    .action_i  (action_e'(action_i)),
    .success_i (init_success_i),
    .cfg_i     (cfg_q),
    .phase_i   (phase_q),
    .count_i   (count_q),
    .period_i  (period_q),
    .retry_i   (retry_q),
    .flags_i   (flags_q),
    .phase_o   (phase_d),
    .count_o   (count_d),
    .period_o  (period_d),
    .retry_o   (retry_d),
    .flags_o   (flags_d),
    .result_o  (res_d)
  );

  // state advances only on an accepted transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhPowerOn;
      count_q  <= '0;
      period_q <= '0;
      retry_q  <= '0;
      flags_q  <= '0;
    end else if (in_xfer) begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      period_q <= period_d;
      retry_q  <= retry_d;
      flags_q  <= flags_d;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, held while the consumer stalls
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o              = out_valid_q;
  assign phase_o                  = res_q.phase;
  assign init_timer_done_event_o  = res_q.done_evt;
  assign retry_limit_event_o      = res_q.limit_evt;
  assign watchdog_timeout_event_o = res_q.wd_evt;
  assign init_done_pending_o      = res_q.done_pending;
  assign retry_limit_reached_o    = res_q.limit_reached;
  assign watchdog_expired_o       = res_q.wd_expired;

endmodule

@@ rtl/dwm_step.sv @@
module dwm_step #(
  parameter int unsigned TIMER_WIDTH = dwm_pkg::TimerWidthDef,
  parameter int unsigned RETRY_WIDTH = dwm_pkg::RetryWidthDef
) (
  input  dwm_pkg::action_e         action_i,
  input  logic                     success_i,
  input  dwm_pkg::cfg_t            cfg_i,
  input  dwm_pkg::phase_e          phase_i,
  input  logic [TIMER_WIDTH-1:0]   count_i,
  input  logic [TIMER_WIDTH-1:0]   period_i,
  input  logic [RETRY_WIDTH:0]     retry_i,
  input  dwm_pkg::flags_t          flags_i,
  output dwm_pkg::phase_e          phase_o,
  output logic [TIMER_WIDTH-1:0]   count_o,
  output logic [TIMER_WIDTH-1:0]   period_o,
  output logic [RETRY_WIDTH:0]     retry_o,
  output dwm_pkg::flags_t          flags_o,
  output dwm_pkg::result_t         result_o
);
  import dwm_pkg::*;

  logic [PeriodW+TIMER_WIDTH-1:0] init_per_ext, wd_per_ext;
  logic [LimitW+RETRY_WIDTH-1:0]  lim_ext;
  logic [TIMER_WIDTH-1:0]         init_per, wd_per;
  logic [RETRY_WIDTH-1:0]         lim;
  logic [RETRY_WIDTH:0]           lim_wide;
  logic                           limited;

  // fit register fields to the parameter widths, zero period used as one
  assign init_per_ext = {{TIMER_WIDTH{1'b0}}, cfg_i.init_period};
  assign wd_per_ext   = {{TIMER_WIDTH{1'b0}}, cfg_i.wd_period};
  assign lim_ext      = {{RETRY_WIDTH{1'b0}}, cfg_i.retry_limit};
  assign lim          = lim_ext[RETRY_WIDTH-1:0];
  assign lim_wide     = {1'b0, lim};
  assign limited      = cfg_i.init_retry_en && (lim != '0);

  always_comb begin
    init_per = init_per_ext[TIMER_WIDTH-1:0];
    if (init_per == '0) begin
      init_per = {{(TIMER_WIDTH-1){1'b0}}, 1'b1};
    end
    wd_per = wd_per_ext[TIMER_WIDTH-1:0];
    if (wd_per == '0) begin
      wd_per = {{(TIMER_WIDTH-1){1'b0}}, 1'b1};
    end
  end

  always_comb begin
    phase_o            = phase_i;
    count_o            = count_i;
    period_o           = period_i;
    retry_o            = retry_i;
    flags_o            = flags_i;
    result_o.done_evt  = 1'b0;
    result_o.limit_evt = 1'b0;
    result_o.wd_evt    = 1'b0;

    case (action_i)
      ActAck: begin
        flags_o.expiry_evt  = 1'b0;
        flags_o.ack_cleared = 1'b1;
        flags_o.ack_success = success_i;
      end
      ActKick: begin
        if (phase_i == PhRun) begin
          flags_o.active  = 1'b0;
          flags_o.expired = 1'b0;
          flags_o.start   = 1'b1;
        end
      end
      ActReset: begin
        flags_o = '0;
        retry_o = '0;
        phase_o = PhPowerOn;
      end
      default: begin
        case (phase_i)
          PhPowerOn: begin
            if (cfg_i.init_wait_en) begin
              period_o        = init_per;
              flags_o.expired = 1'b0;
              flags_o.start   = 1'b1;
              phase_o         = PhInitWait;
            end else begin
              phase_o = PhRun;
              if (cfg_i.wd_en) begin
                period_o        = wd_per;
                flags_o.start   = 1'b1;
                flags_o.expired = 1'b0;
              end
            end
          end
          PhInitWait: begin
            if (flags_i.expired) begin
              flags_o.expired     = 1'b0;
              flags_o.expiry_evt  = 1'b1;
              flags_o.ack_cleared = 1'b0;
              if (limited) begin
                if (!(&retry_i)) begin
                  retry_o = retry_i + {{RETRY_WIDTH{1'b0}}, 1'b1};
                end
                if (retry_o <= lim_wide) begin
                  result_o.done_evt = 1'b1;
                end else begin
                  result_o.limit_evt = 1'b1;
                end
              end else begin
                result_o.done_evt = 1'b1;
              end
            end
            // an expiry in the same tick drops a pending acknowledge
            if (flags_o.ack_cleared) begin
              flags_o.ack_cleared = 1'b0;
              if (flags_i.ack_success) begin
                phase_o = PhRun;
                if (cfg_i.wd_en) begin
                  period_o      = wd_per;
                  flags_o.start = 1'b1;
                end
              end else begin
                flags_o.start = 1'b1;
              end
            end
          end
          PhRun: begin
            if (flags_i.expired) begin
              flags_o.expired = 1'b0;
              if (cfg_i.wd_en) begin
                result_o.wd_evt = 1'b1;
                flags_o.start   = 1'b1;
              end
            end
          end
          default: begin
          end
        endcase

        // shared down-counter: load on pending start, then count the tick
        if (flags_o.start && (period_o != '0)) begin
          flags_o.start  = 1'b0;
          count_o        = period_o;
          flags_o.active = 1'b1;
        end
        if (flags_o.active) begin
          count_o = count_o - {{(TIMER_WIDTH-1){1'b0}}, 1'b1};
          if (count_o == '0) begin
            flags_o.active  = 1'b0;
            flags_o.expired = 1'b1;
          end
        end
      end
    endcase

    result_o.phase         = phase_o;
    result_o.done_pending  = (phase_o == PhInitWait) && flags_o.expiry_evt;
    result_o.limit_reached = limited && (retry_o >= lim_wide);
    result_o.wd_expired    = flags_o.expired && (phase_o == PhRun);
  end

endmodule
